// ===== sv/paired_read_overlap_merge_top_defines.svh =====
// Assertion macros for the paired read overlap merge block.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef PAIRED_READ_OVERLAP_MERGE_TOP_DEFINES_SVH
`define PAIRED_READ_OVERLAP_MERGE_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define PROM_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle
`define PROM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/prom_pkg.sv =====
// Package for the paired read overlap merge block.
// Holds sizes, mode, status and register codes, and the sequencer state type.
`default_nettype none
package prom_pkg;

   localparam int MAX_LEN  = 256;
   localparam int ADDR_W   = $clog2(MAX_LEN);
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int TAB_AW   = $clog2(MAX_LEN + 2);
   localparam int QUAL_OFS = 33;
   localparam int SLACK    = 4;

   localparam logic [1:0] MODE_SUBJECT = 2'd0;
   localparam logic [1:0] MODE_QUERY   = 2'd1;
   localparam logic [1:0] MODE_TABLE   = 2'd2;
   localparam logic [1:0] MODE_DRAIN   = 2'd3;

   localparam logic [1:0] STAT_MERGED    = 2'd0;
   localparam logic [1:0] STAT_NONE      = 2'd1;
   localparam logic [1:0] STAT_AMBIGUOUS = 2'd2;

   localparam logic [2:0] CSR_MIN_OVERLAP    = 3'd0;
   localparam logic [2:0] CSR_QUALITY_CUT    = 3'd1;
   localparam logic [2:0] CSR_REQUIRE_UNIQUE = 3'd2;
   localparam logic [2:0] CSR_MAX_QUALITY    = 3'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OFFSET,
      ST_TAB_WAIT,
      ST_PAIR_RD,
      ST_PAIR_CMP,
      ST_EVAL,
      ST_DRAIN_RD,
      ST_PUSH
   } state_type;

endpackage
`default_nettype wire

// ===== sv/paired_read_overlap_merge_top.sv =====
// Paired read overlap merge.
// Request channel (req_*): mode 0 loads a subject base, mode 1 a query base, mode 2 a
// threshold table entry, mode 3 is a drain tick. A query base with last set starts an
// offset scan; the block drops req_ready until the scan is over and its one status
// transaction (kind 0) is in the output register, which offers it on rsp_*.
// For each tried offset the block waits on the threshold RAM read; then the single base
// pair comparator reads one pair from the subject and query RAMs and compares it, pair
// by pair over the overlap, whose length is the shorter of the subject remainder and
// the query length. A drain tick steps through RAM read, push and back to idle, and
// gives one merged base (kind 1) while a merge is pending; otherwise it is dropped.
// CSR channel (csr_*) is always ready and writes min_overlap, quality_cut, require_unique
// and max_quality by index; write it only while the block is idle.
// Reset (synchronous, active high) clears lengths, status and sequencer; RAM contents are
// kept and are undefined until written.
// A stalled receiver holds the result in the output register; loads and table writes
// are still taken while it waits, and a new result waits in the push state.
`default_nettype none
`include "paired_read_overlap_merge_top_defines.svh"
module paired_read_overlap_merge_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_mode,
   input  wire  [7:0]  req_base,
   input  wire  [6:0]  req_qual,
   input  wire  [8:0]  req_table_index,
   input  wire  [8:0]  req_min_match_value,
   input  wire  [8:0]  req_max_mismatch_value,
   input  wire         req_last,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_overlap_position,
   output logic [7:0]  rsp_merged_base,
   output logic [6:0]  rsp_merged_qual,
   output logic [9:0]  rsp_merged_length,
   output logic        rsp_last_of_merge,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [8:0]  csr_data
);
   import prom_pkg::*;

   state_type state_ff, state_in;

   logic [8:0] min_ov_ff;
   logic [6:0] qcut_ff;
   logic       uniq_ff;
   logic [6:0] maxq_ff;

   logic [LEN_W-1:0] slen_ff, slen_in, qlen_ff, qlen_in;
   logic             s_closed_ff, s_closed_in, q_closed_ff, q_closed_in;
   logic [1:0]       status_ff, status_in;
   logic [8:0]       off_ff, off_in;
   logic [9:0]       drain_ff, drain_in;
   logic [8:0]       pos_ff, pos_in, i_ff, i_in, n_ff, n_in;
   logic [8:0]       match_ff, match_in, mism_ff, mism_in;
   logic             found_ff, found_in;
   logic             pend_kind_ff, pend_kind_in;
   logic             pend_last_ff, pend_last_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kind_ff;
   logic [1:0] rsp_status_ff;
   logic [8:0] rsp_pos_ff;
   logic [7:0] rsp_base_ff;
   logic [6:0] rsp_qual_ff;
   logic [9:0] rsp_len_ff;
   logic       rsp_last_ff;

   logic acc, push_go;
   logic s_we, q_we, t_we;
   logic [ADDR_W-1:0] s_waddr, q_waddr, s_raddr, q_raddr;
   logic [14:0] s_rdata, q_rdata;
   logic [17:0] t_rdata;
   logic [LEN_W-1:0] s_eff, q_eff;
   logic [9:0]  mlen, qend;
   logic [8:0]  pi_sum, diff, end9;
   logic [10:0] lhs, rhs;
   logic        in_range, pass, drain_ok, drain_rd;
   logic [7:0]  sb, qb, qsum, qdiff;
   logic [6:0]  sq, qq, mq;
   logic [9:0]  p_minus;

   assign acc       = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign push_go   = (state_ff == ST_PUSH) && (!rsp_valid_ff || rsp_ready);

   // Base and quality stores, threshold table
   prom_ram #(.WIDTH(15), .DEPTH(MAX_LEN)) u_subject_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data({req_base, req_qual}),
      .rd_addr(s_raddr), .rd_data(s_rdata));
   prom_ram #(.WIDTH(15), .DEPTH(MAX_LEN)) u_query_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data({req_base, req_qual}),
      .rd_addr(q_raddr), .rd_data(q_rdata));
   prom_ram #(.WIDTH(18), .DEPTH(MAX_LEN + 1)) u_table_ram (
      .clock(clock), .wr_en(t_we), .wr_addr(req_table_index[TAB_AW-1:0]),
      .wr_data({req_min_match_value, req_max_mismatch_value}),
      .rd_addr(n_ff[TAB_AW-1:0]), .rd_data(t_rdata));

   // Load addressing: a closed read restarts at zero
   always_comb begin
      s_eff   = s_closed_ff ? '0 : slen_ff;
      q_eff   = q_closed_ff ? '0 : qlen_ff;
      s_waddr = s_eff[ADDR_W-1:0];
      q_waddr = q_eff[ADDR_W-1:0];
      s_we    = acc && (req_mode == MODE_SUBJECT) && (s_eff < LEN_W'(MAX_LEN));
      q_we    = acc && (req_mode == MODE_QUERY) && (q_eff < LEN_W'(MAX_LEN));
      t_we    = acc && (req_mode == MODE_TABLE) && (req_table_index <= 9'(MAX_LEN));
   end

   // Shared datapath: offset window, pair compare, merge arithmetic
   always_comb begin
      qend     = 10'(qlen_ff) + 10'(off_ff);
      mlen     = (10'(slen_ff) > qend) ? 10'(slen_ff) : qend;
      pi_sum   = pos_ff + i_ff;
      p_minus  = drain_ff - 10'(off_ff);
      // Hold the drain address through the push so the read data stays put
      drain_rd = (state_ff == ST_DRAIN_RD) || (state_ff == ST_PUSH);
      s_raddr  = drain_rd ? drain_ff[ADDR_W-1:0] : pi_sum[ADDR_W-1:0];
      q_raddr  = drain_rd ? p_minus[ADDR_W-1:0] : i_ff[ADDR_W-1:0];
      lhs      = 11'(pos_ff) + 11'(min_ov_ff);
      rhs      = 11'(slen_ff) + 11'(SLACK);
      in_range = (9'(slen_ff) > pos_ff) && (lhs < rhs);
      diff     = 9'(slen_ff) - pos_ff;
      pass     = (mism_ff <= t_rdata[8:0]) && (match_ff >= t_rdata[17:9]);
      drain_ok = (status_ff == STAT_MERGED) && (drain_ff < mlen);
      sb       = s_rdata[14:7];
      sq       = s_rdata[6:0];
      qb       = q_rdata[14:7];
      qq       = q_rdata[6:0];
      qsum     = 8'(sq) + 8'(qq);
      qdiff    = (sq > qq) ? 8'(sq - qq) + 8'(QUAL_OFS) : 8'(qq - sq) + 8'(QUAL_OFS);
      if (qsum < 8'(QUAL_OFS)) begin
         mq = '0;
      end else if ((qsum - 8'(QUAL_OFS)) > 8'(maxq_ff)) begin
         mq = maxq_ff;
      end else begin
         mq = 7'(qsum - 8'(QUAL_OFS));
      end
      end9 = (10'(slen_ff) < qend) ? 9'(slen_ff) : qend[8:0];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc && (req_mode == MODE_QUERY) && req_last) begin
               state_in = ST_OFFSET;
            end else if (acc && (req_mode == MODE_DRAIN) && drain_ok) begin
               state_in = ST_DRAIN_RD;
            end
         end
         ST_OFFSET:   state_in = in_range ? ST_TAB_WAIT : ST_PUSH;
         ST_TAB_WAIT: state_in = (n_ff == '0) ? ST_EVAL : ST_PAIR_RD;
         ST_PAIR_RD:  state_in = ST_PAIR_CMP;
         ST_PAIR_CMP: state_in = (i_ff + 9'd1 == n_ff) ? ST_EVAL : ST_PAIR_RD;
         ST_EVAL: begin
            if (pass && (found_ff || !uniq_ff)) begin
               state_in = ST_PUSH;
            end else begin
               state_in = ST_OFFSET;
            end
         end
         ST_DRAIN_RD: state_in = ST_PUSH;
         ST_PUSH:     state_in = push_go ? ST_IDLE : ST_PUSH;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath updates per state
   always_comb begin
      slen_in      = slen_ff;
      qlen_in      = qlen_ff;
      s_closed_in  = s_closed_ff;
      q_closed_in  = q_closed_ff;
      status_in    = status_ff;
      off_in       = off_ff;
      drain_in     = drain_ff;
      pos_in       = pos_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      match_in     = match_ff;
      mism_in      = mism_ff;
      found_in     = found_ff;
      pend_kind_in = pend_kind_ff;
      pend_last_in = pend_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc && (req_mode == MODE_SUBJECT)) begin
               status_in   = STAT_NONE;
               drain_in    = '0;
               slen_in     = s_we ? s_eff + 1'b1 : s_eff;
               s_closed_in = req_last;
            end else if (acc && (req_mode == MODE_QUERY)) begin
               status_in   = STAT_NONE;
               drain_in    = '0;
               qlen_in     = q_we ? q_eff + 1'b1 : q_eff;
               q_closed_in = req_last;
               off_in      = '0;
               pos_in      = '0;
               found_in    = 1'b0;
               pend_kind_in = 1'b0;
            end else if (acc && (req_mode == MODE_DRAIN) && drain_ok) begin
               pend_kind_in = 1'b1;
            end
         end
         ST_OFFSET: begin
            // Set up the overlap length and clear the counters
            n_in     = (diff < 9'(qlen_ff)) ? diff : 9'(qlen_ff);
            i_in     = '0;
            match_in = '0;
            mism_in  = '0;
         end
         ST_PAIR_CMP: begin
            if (sb == qb) begin
               match_in = match_ff + 9'd1;
            end else if ((sq >= qcut_ff) && (qq >= qcut_ff)) begin
               mism_in = mism_ff + 9'd1;
            end
            i_in = i_ff + 9'd1;
         end
         ST_EVAL: begin
            if (pass && found_ff) begin
               status_in = STAT_AMBIGUOUS;
               off_in    = '0;
            end else if (pass) begin
               found_in  = 1'b1;
               status_in = STAT_MERGED;
               off_in    = pos_ff;
            end
            pos_in = pos_ff + 9'd1;
         end
         ST_DRAIN_RD: begin
            // Flag the final merged base
            pend_last_in = (drain_ff + 10'd1 == mlen);
         end
         default: begin
         end
      endcase
   end

   // Merged base selection from the registered RAM data
   logic [7:0] m_base;
   logic [6:0] m_qual;
   always_comb begin
      if ((drain_ff < 10'(off_ff)) ||
          ((drain_ff >= 10'(end9)) && (10'(slen_ff) >= qend))) begin
         m_base = sb;
         m_qual = sq;
      end else if (drain_ff >= 10'(end9)) begin
         m_base = qb;
         m_qual = qq;
      end else if (sb == qb) begin
         m_base = sb;
         m_qual = mq;
      end else begin
         m_base = (sq > qq) ? sb : qb;
         m_qual = (qdiff > 8'd127) ? 7'd127 : qdiff[6:0];
      end
   end

   // Output register load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (push_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slen_ff      <= '0;
         qlen_ff      <= '0;
         s_closed_ff  <= 1'b0;
         q_closed_ff  <= 1'b0;
         status_ff    <= STAT_NONE;
         off_ff       <= '0;
         drain_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_ov_ff    <= 9'd15;
         qcut_ff      <= 7'd46;
         uniq_ff      <= 1'b1;
         maxq_ff      <= 7'd74;
      end else begin
         state_ff     <= state_in;
         slen_ff      <= slen_in;
         qlen_ff      <= qlen_in;
         s_closed_ff  <= s_closed_in;
         q_closed_ff  <= q_closed_in;
         status_ff    <= status_in;
         off_ff       <= off_in;
         drain_ff     <= (push_go && pend_kind_ff) ? drain_ff + 10'd1 : drain_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_OVERLAP:    min_ov_ff <= csr_data;
               CSR_QUALITY_CUT:    qcut_ff   <= csr_data[6:0];
               CSR_REQUIRE_UNIQUE: uniq_ff   <= csr_data[0];
               CSR_MAX_QUALITY:    maxq_ff   <= csr_data[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      i_ff         <= i_in;
      n_ff         <= n_in;
      match_ff     <= match_in;
      mism_ff      <= mism_in;
      pend_kind_ff <= pend_kind_in;
      pend_last_ff <= pend_last_in;
      if (push_go) begin
         rsp_kind_ff <= pend_kind_ff;
         if (pend_kind_ff) begin
            rsp_status_ff <= STAT_MERGED;
            rsp_pos_ff    <= off_ff;
            rsp_base_ff   <= m_base;
            rsp_qual_ff   <= m_qual;
            rsp_len_ff    <= mlen;
            rsp_last_ff   <= pend_last_ff;
         end else begin
            rsp_status_ff <= status_ff;
            rsp_pos_ff    <= (status_ff == STAT_MERGED) ? off_ff : '0;
            rsp_base_ff   <= '0;
            rsp_qual_ff   <= '0;
            rsp_len_ff    <= (status_ff == STAT_MERGED) ? mlen : '0;
            rsp_last_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_overlap_position = rsp_pos_ff;
   assign rsp_merged_base      = rsp_base_ff;
   assign rsp_merged_qual      = rsp_qual_ff;
   assign rsp_merged_length    = rsp_len_ff;
   assign rsp_last_of_merge    = rsp_last_ff;

   `PROM_ASSERT_NOW(a_ready_idle, !req_ready || (state_ff == ST_IDLE), "ready outside idle")
   `PROM_ASSERT_NOW(a_pair_bound, (state_ff != ST_PAIR_CMP) || (i_ff < n_ff), "pair past overlap")
   `PROM_ASSERT_NEXT(a_push_valid, push_go, rsp_valid_ff, "push lost result")
   `PROM_ASSERT_NOW(a_stat_pos, !(rsp_valid_ff && !rsp_kind_ff && (rsp_status_ff != STAT_MERGED)) || (rsp_pos_ff == '0), "offset on failed scan")
endmodule
`default_nettype wire

// ===== sv/prom_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module prom_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write when enabled, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
